### rtl/psma_pkg.sv
package psma_pkg;

  typedef struct packed {
    logic [7:0]  symbol_id;
    logic        trade_valid;
    logic [31:0] trade_price;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sma_value;
    logic [31:0] ema_value;
  } out_item_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SMA_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA  = 1'd1;

  localparam logic [4:0]  SMA_PERIOD_RST = 5'd10;
  localparam logic [16:0] EMA_ALPHA_RST  = 17'd11916;

  localparam logic [16:0] ALPHA_ONE  = 17'd65536;
  localparam logic [16:0] ALPHA_HALF = 17'd32768;

endpackage

### rtl/per_symbol_moving_averages.sv
// channel | direction | handshake                  | payload
// in      | input     | in_valid / in_stall        | in_data   (psma_pkg::in_item_t)
// out     | output    | out_valid / out_stall      | out_data  (psma_pkg::out_item_t)
// cfg     | input     | cfg_wr_en (no wait)        | cfg_index, cfg_data
//
// a tick with a trade runs through state load, up to two window drops
// (each a check and a drop step), the sum / count divider at 2 quotient bits per cycle
// and two passes of the shared 32x17 multiplier
// a tick without a trade, or with a symbol out of range, goes straight to the finish state
// after reset the per-symbol state of every symbol is cleared, in_stall held high
// one item is in work at a time; a finished result sits in the output register
// and the block waits at the end of the next item only while out_stall keeps it there
module per_symbol_moving_averages #(
  parameter int NUM_SYMBOLS = 256,
  parameter int MAX_PERIOD  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  psma_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output psma_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [psma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psma_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SYM_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int HEAD_W    = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int SLOT_W    = HEAD_W + 1;
  localparam int CNT_W     = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W     = 32 + $clog2(MAX_PERIOD);
  localparam int DIV_STEPS = (SUM_W + 1) / 2;
  localparam int DIV_W     = 2 * DIV_STEPS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int ACC_W     = 32 + 17;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [31:0]       ema;
    logic              started;
  } sym_state_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOAD, S_CHK, S_DROP, S_WR, S_DIV, S_EMA1, S_EMA2, S_FIN
  } state_t;

  state_t              state_r;
  logic [SYM_W-1:0]    clr_idx_r;
  logic [4:0]          sma_period_r;
  logic [16:0]         ema_alpha_r;

  logic [SYM_W-1:0]    sym_r;
  logic                trade_r;
  logic [31:0]         price_r;
  logic [HEAD_W-1:0]   head_r;
  logic [CNT_W-1:0]    count_r;
  logic [SUM_W-1:0]    sum_r;
  logic [31:0]         ema_r;
  logic                started_r;
  logic [1:0]          drops_r;
  logic [DIV_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [STEP_W-1:0]   step_r;
  logic [ACC_W-1:0]    acc_r;

  logic                out_valid_r;
  psma_pkg::out_item_t out_data_r;

  // per-symbol state and price ring memories
  sym_state_t          st_mem [NUM_SYMBOLS];
  sym_state_t          st_q_r;
  sym_state_t          st_wdata;
  logic                st_we;
  logic [SYM_W-1:0]    st_waddr;
  logic [SYM_W-1:0]    st_raddr;

  logic [31:0]         pw_mem [NUM_SYMBOLS][MAX_PERIOD];
  logic [31:0]         pw_q_r;
  logic                pw_we;

  logic                in_accept;
  logic                in_range;
  logic                fin_go;
  logic [CNT_W-1:0]    period_eff;
  logic [16:0]         alpha_eff;
  logic [SLOT_W-1:0]   old_tmp;
  logic [HEAD_W-1:0]   old_slot;
  logic [HEAD_W-1:0]   head_inc;
  logic [SUM_W-1:0]    sum_add;
  logic                drop_need;
  logic [DIV_W-1:0]    quo_nxt;
  logic [CNT_W-1:0]    rem_nxt;
  logic [31:0]         mul_x;
  logic [16:0]         mul_y;
  logic [ACC_W-1:0]    prod;
  logic [31:0]         ema_new;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_range  = (32'(in_data.symbol_id) < 32'(NUM_SYMBOLS));
  assign fin_go    = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (sma_period_r == 5'd0) begin
      period_eff = CNT_W'(1);
    end else if (32'(sma_period_r) > MAX_PERIOD) begin
      period_eff = CNT_W'(MAX_PERIOD);
    end else begin
      period_eff = CNT_W'(sma_period_r);
    end
    alpha_eff = (ema_alpha_r > psma_pkg::ALPHA_ONE) ? psma_pkg::ALPHA_ONE : ema_alpha_r;
  end

  // oldest slot of the ring: head - count, modulo the ring length
  always_comb begin
    old_tmp   = SLOT_W'(head_r) + SLOT_W'(MAX_PERIOD) - SLOT_W'(count_r);
    old_slot  = (32'(old_tmp) >= MAX_PERIOD) ? HEAD_W'(old_tmp - SLOT_W'(MAX_PERIOD))
                                             : HEAD_W'(old_tmp);
    head_inc  = (32'(head_r) == MAX_PERIOD - 1) ? '0 : head_r + HEAD_W'(1);
    sum_add   = sum_r + SUM_W'(price_r);
    drop_need = (count_r >= period_eff) && (drops_r != 2'd2);
  end

  // restoring divider, two quotient bits per cycle
  always_comb begin
    logic [CNT_W:0]   r;
    logic [CNT_W-1:0] rem;
    logic [DIV_W-1:0] q;
    rem = rem_r;
    q   = quo_r;
    for (int k = 0; k < 2; k++) begin
      r = {rem, q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, count_r}) begin
        r    = r - {1'b0, count_r};
        q[0] = 1'b1;
      end
      rem = r[CNT_W-1:0];
    end
    quo_nxt = q;
    rem_nxt = rem;
  end

  // shared multiplier: price * alpha, then average * (one - alpha)
  always_comb begin
    if (state_r == S_EMA1) begin
      mul_x = price_r;
      mul_y = alpha_eff;
    end else begin
      mul_x = ema_r;
      mul_y = psma_pkg::ALPHA_ONE - alpha_eff;
    end
    prod    = ACC_W'(mul_x) * ACC_W'(mul_y);
    ema_new = started_r ? 32'(acc_r >> 16) : price_r;
  end

  always_comb begin
    st_raddr = SYM_W'(in_data.symbol_id);
    st_we    = (state_r == S_CLR) || ((state_r == S_FIN) && trade_r && fin_go);
    st_waddr = (state_r == S_CLR) ? clr_idx_r : sym_r;
    if (state_r == S_CLR) begin
      st_wdata = '0;
    end else begin
      st_wdata.head    = head_r;
      st_wdata.count   = count_r;
      st_wdata.sum     = sum_r;
      st_wdata.ema     = ema_new;
      st_wdata.started = 1'b1;
    end
    pw_we = (state_r == S_WR);
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_q_r <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (pw_we) begin
      pw_mem[sym_r][head_r] <= price_r;
    end
    pw_q_r <= pw_mem[sym_r][old_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_idx_r    <= '0;
      sma_period_r <= psma_pkg::SMA_PERIOD_RST;
      ema_alpha_r  <= psma_pkg::EMA_ALPHA_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          psma_pkg::CFG_SMA_PERIOD: sma_period_r <= cfg_data[4:0];
          psma_pkg::CFG_EMA_ALPHA:  ema_alpha_r  <= cfg_data;
        endcase
      end

      if ((state_r == S_FIN) && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLR: begin
          clr_idx_r <= clr_idx_r + SYM_W'(1);
          if (clr_idx_r == SYM_W'(NUM_SYMBOLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            sym_r   <= SYM_W'(in_data.symbol_id);
            price_r <= in_data.trade_price;
            trade_r <= in_data.trade_valid && in_range;
            drops_r <= 2'd0;
            state_r <= (in_data.trade_valid && in_range) ? S_LOAD : S_FIN;
          end
        end
        S_LOAD: begin
          head_r    <= st_q_r.head;
          count_r   <= st_q_r.count;
          sum_r     <= st_q_r.sum;
          ema_r     <= st_q_r.ema;
          started_r <= st_q_r.started;
          state_r   <= S_CHK;
        end
        S_CHK: begin
          state_r <= drop_need ? S_DROP : S_WR;
        end
        S_DROP: begin
          sum_r   <= sum_r - SUM_W'(pw_q_r);
          count_r <= count_r - CNT_W'(1);
          drops_r <= drops_r + 2'd1;
          state_r <= S_CHK;
        end
        S_WR: begin
          head_r  <= head_inc;
          count_r <= count_r + CNT_W'(1);
          sum_r   <= sum_add;
          quo_r   <= DIV_W'(sum_add);
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= S_EMA1;
          end
        end
        S_EMA1: begin
          acc_r   <= prod + ACC_W'(psma_pkg::ALPHA_HALF);
          state_r <= S_EMA2;
        end
        S_EMA2: begin
          acc_r   <= acc_r + prod;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            if (trade_r) begin
              out_data_r.sma_value <= quo_r[31:0];
              out_data_r.ema_value <= ema_new;
            end else begin
              out_data_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/per_symbol_moving_averages_tb.sv
module per_symbol_moving_averages_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SYM    = 256;
  localparam int WIN_DEPTH  = 16;
  localparam int RUN_LIMIT  = 1000000;
  localparam int TAIL_WAIT  = 40;
  localparam int NUM_PHASES = 9;
  localparam int RAND_TICKS = 220;
  localparam int LIST_DEPTH = 4096;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  psma_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psma_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [psma_pkg::CFG_IDX_W-1:0] cfg_index = psma_pkg::CFG_SMA_PERIOD;
  logic [psma_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  per_symbol_moving_averages u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // per-symbol averaging state, mirrored from what the block should hold
  logic [31:0] win_price [NUM_SYM][WIN_DEPTH];
  logic [3:0]  win_head [NUM_SYM];
  logic [4:0]  win_count [NUM_SYM];
  logic [35:0] win_sum [NUM_SYM];
  logic [31:0] ema_level [NUM_SYM];
  logic        ema_seeded [NUM_SYM];
  logic [4:0]  period_reg;
  logic [16:0] alpha_reg;

  // pending ticks and expected results, kept as lists with read and write counts
  psma_pkg::in_item_t  tick_list [LIST_DEPTH];
  psma_pkg::out_item_t want_list [LIST_DEPTH];
  int tick_wr = 0;
  int tick_rd = 0;
  int want_wr = 0;
  int want_rd = 0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int ticks_accepted = 0;
  int trades_accepted = 0;
  int results_checked = 0;
  int cycle_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic psma_pkg::out_item_t advance_averages(psma_pkg::in_item_t tick);
    logic [7:0]  s;
    logic [4:0]  per;
    logic [16:0] a;
    logic [3:0]  slot;
    logic [35:0] quot;
    logic [48:0] mix;
    psma_pkg::out_item_t r;
    r = '0;
    s = tick.symbol_id;
    if (tick.trade_valid) begin
      if (period_reg == 5'd0) per = 5'd1;
      else if (period_reg > 5'(WIN_DEPTH)) per = 5'(WIN_DEPTH);
      else per = period_reg;
      // after the period shrinks, two old prices leave per trade
      for (int k = 0; k < 2; k++) begin
        if (win_count[s] >= per) begin
          slot = win_head[s] - win_count[s][3:0];
          win_sum[s] = win_sum[s] - {4'd0, win_price[s][slot]};
          win_count[s] = win_count[s] - 5'd1;
        end
      end
      win_price[s][win_head[s]] = tick.trade_price;
      win_head[s] = win_head[s] + 4'd1;
      win_count[s] = win_count[s] + 5'd1;
      win_sum[s] = win_sum[s] + {4'd0, tick.trade_price};
      quot = win_sum[s] / {31'd0, win_count[s]};
      r.sma_value = quot[31:0];
      if (!ema_seeded[s]) begin
        ema_level[s] = tick.trade_price;
        ema_seeded[s] = 1'b1;
      end else begin
        a = (alpha_reg > psma_pkg::ALPHA_ONE) ? psma_pkg::ALPHA_ONE : alpha_reg;
        mix = 49'(tick.trade_price) * 49'(a)
              + 49'(ema_level[s]) * 49'(psma_pkg::ALPHA_ONE - a)
              + 49'(psma_pkg::ALPHA_HALF);
        ema_level[s] = mix[47:16];
      end
      r.ema_value = ema_level[s];
    end
    return r;
  endfunction

  function automatic void push_tick(logic [7:0] sym, logic trade, logic [31:0] price);
    psma_pkg::in_item_t t;
    t.symbol_id = sym;
    t.trade_valid = trade;
    t.trade_price = price;
    tick_list[tick_wr % LIST_DEPTH] = t;
    tick_wr++;
  endfunction

  task automatic write_reg(logic [psma_pkg::CFG_IDX_W-1:0] idx,
                           logic [psma_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == psma_pkg::CFG_SMA_PERIOD) period_reg = val[4:0];
    else alpha_reg = val;
  endtask

  // input driver: an item stays on the bus until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        want_list[want_wr % LIST_DEPTH] = advance_averages(in_data);
        want_wr++;
        ticks_accepted++;
        if (in_data.trade_valid) trades_accepted++;
      end
      if (tick_rd != tick_wr && $urandom_range(99) >= send_idle_pct) begin
        in_data <= tick_list[tick_rd % LIST_DEPTH];
        tick_rd++;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    psma_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_rd == want_wr) begin
          errors++;
          $display("%0t: result with nothing expected: sma %h ema %h", $time,
                   out_data.sma_value, out_data.ema_value);
        end else begin
          want = want_list[want_rd % LIST_DEPTH];
          want_rd++;
          results_checked++;
          if (out_data.sma_value !== want.sma_value) begin
            errors++;
            $display("%0t: sma_value expected %h got %h", $time, want.sma_value,
                     out_data.sma_value);
          end
          if (out_data.ema_value !== want.ema_value) begin
            errors++;
            $display("%0t: ema_value expected %h got %h", $time, want.ema_value,
                     out_data.ema_value);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time,
               want_wr - want_rd);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int period_plan [NUM_PHASES];
    int alpha_plan [NUM_PHASES];
    logic [7:0]  sym;
    logic [31:0] price;
    period_plan = '{10, 1, 16, 3, 0, 31, 16, 5, -1};
    alpha_plan = '{11916, 65536, 0, 131071, 1, 32768, -1, -1, -1};
    for (int s = 0; s < NUM_SYM; s++) begin
      win_head[s] = '0;
      win_count[s] = '0;
      win_sum[s] = '0;
      ema_level[s] = '0;
      ema_seeded[s] = 1'b0;
    end
    period_reg = psma_pkg::SMA_PERIOD_RST;
    alpha_reg = psma_pkg::EMA_ALPHA_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed ticks at the reset settings
    push_tick(8'd0, 1'b1, 32'h0000_0000);
    push_tick(8'd0, 1'b1, 32'hFFFF_FFFF);
    push_tick(8'd0, 1'b0, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) push_tick(8'd255, 1'b1, 32'hFFFF_FFFF);
    push_tick(8'd255, 1'b0, 32'h0000_0000);
    push_tick(8'd0, 1'b1, 32'h0001_0000);
    push_tick(8'd128, 1'b1, 32'h8000_0000);
    push_tick(8'd128, 1'b1, 32'h7FFF_FFFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        write_reg(psma_pkg::CFG_SMA_PERIOD, (period_plan[p] < 0) ?
                  psma_pkg::CFG_DATA_W'($urandom_range(16, 1)) :
                  psma_pkg::CFG_DATA_W'(period_plan[p]));
        write_reg(psma_pkg::CFG_EMA_ALPHA, (alpha_plan[p] < 0) ?
                  psma_pkg::CFG_DATA_W'($urandom_range(65536, 1)) :
                  psma_pkg::CFG_DATA_W'(alpha_plan[p]));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      // mostly a few busy symbols so windows fill and wrap, some anywhere
      for (int i = 0; i < RAND_TICKS; i++) begin
        case ($urandom_range(9))
          0: sym = 8'd0;
          1: sym = 8'd1;
          2: sym = 8'd2;
          3: sym = 8'd128;
          4: sym = 8'd254;
          5: sym = 8'd255;
          6, 7: sym = 8'($urandom_range(7));
          default: sym = 8'($urandom_range(255));
        endcase
        case ($urandom_range(9))
          0: price = 32'h0000_0000;
          1: price = 32'hFFFF_FFFF;
          2, 3: price = 32'h0064_0000 + $urandom_range(32'h0004_0000);
          default: price = $urandom;
        endcase
        push_tick(sym, ($urandom_range(99) < 85), price);
      end
      while (tick_rd != tick_wr || in_valid || want_rd != want_wr)
        @(posedge clk);
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (want_rd != want_wr) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, want_wr - want_rd);
    end
    $display("%0d ticks (%0d trades) over %0d register settings, %0d results checked",
             ticks_accepted, trades_accepted, NUM_PHASES, results_checked);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/psma_pkg.sv
rtl/per_symbol_moving_averages.sv
tb/per_symbol_moving_averages_tb.sv
